/* rtl/isa_pkg.sv */
`timescale 1ns / 1ps

package isa_pkg;

	typedef enum logic [1:0] {
		KIND_READ   = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_INSERT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DONE
	} state_t;

	// per-cycle command broadcast to every cell of the row
	typedef struct packed {
		logic wr;     // write the target cell this cycle
		logic shift;  // cells above the target take their lower neighbor
		logic rd;     // target cell drives its word onto the read tree
	} cell_ctl_t;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned KIND_W   = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned TREE_RADIX_LOG = 3;

endpackage

/* rtl/isa_in_if.sv */
`timescale 1ns / 1ps

interface isa_in_if #(
	parameter int unsigned IDX_W = 7
);
	logic                 valid;
	logic                 ready;
	logic [1:0]           kind;
	logic signed [31:0]   value;
	logic [IDX_W-1:0]     position;

	modport source (output valid, kind, value, position, input ready);
	modport sink   (input valid, kind, value, position, output ready);
endinterface

/* rtl/isa_out_if.sv */
`timescale 1ns / 1ps

interface isa_out_if #(
	parameter int unsigned IDX_W = 7
);
	logic                 valid;
	logic                 ready;
	logic signed [31:0]   read_value;
	logic [1:0]           status;
	logic [IDX_W-1:0]     count_now;

	modport source (output valid, read_value, status, count_now, input ready);
	modport sink   (input valid, read_value, status, count_now, output ready);
endinterface

/* rtl/insertable_shift_array.sv */
`timescale 1ns / 1ps

// Fixed-capacity array of signed 32-bit words with a fill count, held in a
// row of CAPACITY cells, one word per cell. Each transfer on in_ch is a read
// at a position, an append, or an insert before a position; each gives one
// transfer on out_ch with the read word (zero unless a read succeeded), a
// status (done, position out of range, full) and the count after the
// operation. Append and insert finish in the cycle they are accepted: every
// cell above the insert point takes its lower neighbor's word in that same
// cycle, so writes run at one per cycle as long as out_ch keeps up. A read
// gathers the selected cell through a registered radix-8 OR tree; a read
// out of range answers at once. One item is in flight at a time; a new item
// is accepted in the cycle the previous result is taken. Entries are cleared
// logically at reset by the fill count: a cell above the count is never read.
module insertable_shift_array #(
	parameter int unsigned CAPACITY = 64,
	parameter int unsigned IDX_W    = $clog2(CAPACITY + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	isa_in_if.sink         in_ch,
	isa_out_if.source      out_ch
);
	import isa_pkg::*;

	localparam int unsigned LEVELS = ($clog2(CAPACITY) + TREE_RADIX_LOG - 1) / TREE_RADIX_LOG;
	localparam int unsigned WAIT_W = $clog2(LEVELS + 1);

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  count_q, count_d;
	logic [IDX_W-1:0]  tgt_q;
	logic [WAIT_W-1:0] wait_q;

	logic              out_valid_q;
	logic [WORD_W-1:0] rdv_q;
	logic [1:0]        st_q;
	logic [IDX_W-1:0]  cnt_q;

	logic              out_free;
	logic              accept;
	logic              load_out;
	logic [WORD_W-1:0] load_rdv;
	status_t           load_st;

	logic              is_full;
	logic              rd_ok;
	logic              ins_range;
	logic              go_read;
	cell_ctl_t         ctl;
	logic [IDX_W-1:0]  wr_target;
	logic [IDX_W-1:0]  target;
	status_t           imm_st;

	logic [WORD_W-1:0] word [CAPACITY];
	logic [WORD_W-1:0] tap  [CAPACITY];
	logic [WORD_W-1:0] root;

	assign out_free    = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == S_IDLE) && out_free;
	assign accept      = in_ch.valid && in_ch.ready;

	assign is_full   = (count_q == IDX_W'(CAPACITY));
	assign rd_ok     = (in_ch.position < count_q);
	assign ins_range = (in_ch.position > count_q);

	// decode the request: write command for the row, immediate status
	always_comb begin
		ctl       = '0;
		wr_target = in_ch.position;
		go_read   = 1'b0;
		imm_st    = ST_DONE;
		count_d   = count_q;
		case (in_ch.kind)
			KIND_READ: begin
				if (rd_ok) begin
					go_read = 1'b1;
				end else begin
					imm_st = ST_RANGE;
				end
			end
			KIND_APPEND: begin
				wr_target = count_q;
				if (is_full) begin
					imm_st = ST_FULL;
				end else begin
					ctl.wr  = accept;
					count_d = count_q + 1'b1;
				end
			end
			KIND_INSERT: begin
				if (ins_range) begin
					imm_st = ST_RANGE;
				end else if (is_full) begin
					imm_st = ST_FULL;
				end else begin
					ctl.wr    = accept;
					ctl.shift = 1'b1;
					count_d   = count_q + 1'b1;
				end
			end
			default: begin
				imm_st = ST_RANGE;
			end
		endcase
		// while a read runs, hold the row still and select the latched position
		ctl.rd = (state_q != S_IDLE);
		target = (state_q == S_IDLE) ? wr_target : tgt_q;
	end

	// sequencer: next state and result load
	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		load_rdv = '0;
		load_st  = imm_st;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (go_read) begin
						state_d = S_READ;
					end else begin
						load_out = 1'b1;
					end
				end
			end
			S_READ: begin
				if (wait_q == WAIT_W'(LEVELS - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					load_out = 1'b1;
					load_rdv = root;
					load_st  = ST_DONE;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			wait_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q <= count_d;
			end
			// count tree levels while the read drains
			if (state_q == S_READ) begin
				wait_q <= wait_q + 1'b1;
			end else begin
				wait_q <= '0;
			end
		end
	end

	// latch the read position for the tree walk
	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_q <= in_ch.position;
		end
	end

	// output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rdv_q <= load_rdv;
			st_q  <= load_st;
			cnt_q <= (state_q == S_IDLE) ? count_d : count_q;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.read_value = rdv_q;
	assign out_ch.status     = st_q;
	assign out_ch.count_now  = cnt_q;

	// row of cells, cell 0 at the bottom takes zero from below
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_W-1:0] lower;
		if (i == 0) begin : g_bottom
			assign lower = '0;
		end else begin : g_link
			assign lower = word[i-1];
		end
		isa_cell #(
			.INDEX (i),
			.IDX_W (IDX_W)
		) u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.target (target),
			.value  (in_ch.value),
			.lower  (lower),
			.word   (word[i]),
			.tap    (tap[i])
		);
	end

	isa_or_tree #(
		.LEAVES (CAPACITY),
		.LEVELS (LEVELS)
	) u_tree (
		.clk  (clk),
		.leaf (tap),
		.root (root)
	);
endmodule

/* rtl/isa_cell.sv */
`timescale 1ns / 1ps

module isa_cell #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned IDX_W = 7
) (
	input  logic                         clk,
	input  isa_pkg::cell_ctl_t           ctl,
	input  logic [IDX_W-1:0]             target,
	input  logic [isa_pkg::WORD_W-1:0]   value,
	input  logic [isa_pkg::WORD_W-1:0]   lower,
	output logic [isa_pkg::WORD_W-1:0]   word,
	output logic [isa_pkg::WORD_W-1:0]   tap
);
	import isa_pkg::*;

	logic [WORD_W-1:0] word_q;
	logic              hit;
	logic              above;

	assign hit   = (target == IDX_W'(INDEX));
	assign above = (IDX_W'(INDEX) > target);

	// load at the target, move up above it, hold elsewhere
	always_ff @(posedge clk) begin
		if (ctl.wr && hit) begin
			word_q <= value;
		end else if (ctl.wr && ctl.shift && above) begin
			word_q <= lower;
		end
	end

	assign word = word_q;
	assign tap  = (ctl.rd && hit) ? word_q : '0;
endmodule

/* rtl/isa_or_tree.sv */
`timescale 1ns / 1ps

module isa_or_tree #(
	parameter int unsigned LEAVES = 64,
	parameter int unsigned LEVELS = 2
) (
	input  logic                         clk,
	input  logic [isa_pkg::WORD_W-1:0]   leaf [LEAVES],
	output logic [isa_pkg::WORD_W-1:0]   root
);
	import isa_pkg::*;

	localparam int unsigned RADIX = 1 << TREE_RADIX_LOG;
	localparam int unsigned PAD   = 1 << (TREE_RADIX_LOG * LEVELS);

	logic [WORD_W-1:0] node [LEVELS+1][PAD];

	for (genvar j = 0; j < PAD; j++) begin : g_leaf
		if (j < LEAVES) begin : g_used
			assign node[0][j] = leaf[j];
		end else begin : g_pad
			assign node[0][j] = '0;
		end
	end

	// one register level per radix-8 merge
	for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
		localparam int unsigned N_OUT = PAD >> (TREE_RADIX_LOG * (k + 1));
		for (genvar j = 0; j < PAD; j++) begin : g_node
			if (j < N_OUT) begin : g_or
				always_ff @(posedge clk) begin
					logic [WORD_W-1:0] acc;
					acc = '0;
					for (int r = 0; r < RADIX; r++) begin
						acc = acc | node[k][j*RADIX + r];
					end
					node[k+1][j] <= acc;
				end
			end else begin : g_zero
				assign node[k+1][j] = '0;
			end
		end
	end

	assign root = node[LEVELS][0];
endmodule

/* sim/shift_array_checker.sv */
`timescale 1ns / 1ps

module shift_array_checker #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	isa_in_if     in_ch,
	isa_out_if    out_ch,
	output int    errors,
	output int    pending,
	output int    fill_hint
);
	import isa_pkg::*;

	typedef struct {
		logic [31:0] read_value;
		logic [1:0]  status;
		logic [6:0]  count_now;
	} array_reply_t;

	logic [31:0]  model_words [CAPACITY];
	int           model_count = 0;
	int           mismatch_count = 0;
	int           replies_owed = 0;
	int           count_seen = 0;
	array_reply_t expected_replies [$];
	array_reply_t want;

	assign errors    = mismatch_count;
	assign pending   = replies_owed;
	assign fill_hint = count_seen;

	// Apply one operation to the shadow array; return the reply it should give.
	function automatic array_reply_t apply_array_op(input logic [1:0] op,
			input logic [31:0] word, input logic [6:0] pos);
		array_reply_t r;
		int i;
		r.read_value = '0;
		r.status     = ST_DONE;
		case (op)
			KIND_READ: begin
				if (pos < model_count)
					r.read_value = model_words[pos];
				else
					r.status = ST_RANGE;
			end
			KIND_APPEND: begin
				if (model_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					model_words[model_count] = word;
					model_count++;
				end
			end
			KIND_INSERT: begin
				// range is checked before fullness
				if (pos > model_count) begin
					r.status = ST_RANGE;
				end else if (model_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (i = model_count; i > pos; i--)
						model_words[i] = model_words[i-1];
					model_words[pos] = word;
					model_count++;
				end
			end
			default: r.status = ST_RANGE;
		endcase
		r.count_now = model_count[6:0];
		return r;
	endfunction

	task automatic flag_field(input string what, input longint exp_val, input longint got_val);
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, exp_val, got_val);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_replies.delete();
			model_count = 0;
			foreach (model_words[i])
				model_words[i] = '0;
			replies_owed <= 0;
			count_seen   <= 0;
		end else begin
			// queue before pop, so a same-edge reply still meets the oldest entry
			if (in_ch.valid && in_ch.ready)
				expected_replies.insert(expected_replies.size(),
					apply_array_op(in_ch.kind, in_ch.value, in_ch.position));
			if (out_ch.valid && out_ch.ready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t ns: unexpected reply, read_value %0d status %0d count %0d",
						$time, out_ch.read_value, out_ch.status, out_ch.count_now);
					mismatch_count++;
				end else begin
					want = expected_replies.pop_front();
					if (out_ch.read_value !== want.read_value)
						flag_field("read_value", $signed(want.read_value),
							$signed(out_ch.read_value));
					if (out_ch.status !== want.status)
						flag_field("status", want.status, out_ch.status);
					if (out_ch.count_now !== want.count_now)
						flag_field("count_now", want.count_now, out_ch.count_now);
				end
			end
			replies_owed <= expected_replies.size();
			count_seen   <= model_count;
		end
	end

endmodule

/* sim/insertable_shift_array_tb.sv */
`timescale 1ns / 1ps

module insertable_shift_array_tb;
	import isa_pkg::*;

	localparam int unsigned CAPACITY = 64;
	localparam int unsigned IDX_W    = 7;
	localparam int          LIMIT    = 200000;
	localparam int          PER_PHASE = 113;
	// code that the block must reject as an invalid request
	localparam logic [1:0]  KIND_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   pending;
	int   fill_hint;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   cycle_count = 0;

	isa_in_if  #(.IDX_W(IDX_W)) in_ch ();
	isa_out_if #(.IDX_W(IDX_W)) out_ch ();

	insertable_shift_array #(
		.CAPACITY(CAPACITY),
		.IDX_W   (IDX_W)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch),
		.out_ch(out_ch)
	);

	shift_array_checker #(.CAPACITY(CAPACITY)) checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.errors   (errors),
		.pending  (pending),
		.fill_hint(fill_hint)
	);

	always #6 clk = ~clk;

	// Drop ready at random; stall_pct is set per phase by the stimulus.
	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("insertable_shift_array_tb: FAIL");
			$finish;
		end
	end

	// Offer one operation and hold it until the transfer happens. Idle cycles
	// come first, so valid is never lowered and raised at the same edge.
	task automatic offer_op(input logic [1:0] op, input logic [31:0] word,
			input logic [6:0] pos);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.kind     <= op;
		in_ch.value    <= word;
		in_ch.position <= pos;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Hold the sender off until every reply owed has come back.
	task automatic drain_replies();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [1:0]  op;
		logic [31:0] word;
		logic [6:0]  pos;
		int          roll;
		int          phase;
		int          n;
		int          k;

		arst_n         = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.kind     = KIND_READ;
		in_ch.value    = '0;
		in_ch.position = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty array, insert at and beyond the count, word extremes,
		// reads in and out of range, the unused code.
		offer_op(KIND_READ,   32'h0,          7'd0);
		offer_op(KIND_INSERT, 32'h5,          7'd1);
		offer_op(KIND_INSERT, 32'h7FFF_FFFF,  7'd0);
		offer_op(KIND_APPEND, 32'h8000_0000,  7'd0);
		offer_op(KIND_INSERT, 32'hFFFF_FFFF,  7'd0);
		offer_op(KIND_INSERT, 32'h0,          7'd1);
		offer_op(KIND_INSERT, 32'h5A5A_A5A5,  7'd2);
		offer_op(KIND_INSERT, 32'h1234_5678,  7'd5);
		for (k = 0; k <= 6; k++)
			offer_op(KIND_READ, 32'hFFFF_FFFF, k[6:0]);
		offer_op(KIND_READ,   32'h0,          7'd127);
		offer_op(KIND_INSERT, 32'h1,          7'd127);
		offer_op(KIND_INSERT, 32'h2,          7'd7);
		offer_op(KIND_UNUSED, 32'hFFFF_FFFF,  7'd0);
		offer_op(KIND_UNUSED, 32'h0,          7'd127);
		offer_op(KIND_APPEND, 32'h0000_0001,  7'd127);
		offer_op(KIND_READ,   32'h0,          7'd6);
		drain_replies();

		// Random: mostly reads of held entries, with writes sparse enough that
		// the array fills around the middle of the run and then stays full,
		// so the full cases get plenty of traffic too.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 55; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 55; end
				default: begin idle_pct = 13; stall_pct = 13; end
			endcase
			for (n = 0; n < PER_PHASE; n++) begin
				case ($urandom_range(7))
					0: word = 32'h7FFF_FFFF;
					1: word = 32'h8000_0000;
					2: word = 32'h0;
					3: word = 32'hFFFF_FFFF;
					default: word = $urandom;
				endcase
				roll = $urandom_range(99);
				if (roll < 63) begin
					op = KIND_READ;
					if (fill_hint > 0 && $urandom_range(9) < 8)
						pos = 7'($urandom_range(fill_hint - 1, 0));
					else
						pos = 7'($urandom_range(127, 0));
				end else if (roll < 73) begin
					op  = KIND_APPEND;
					pos = 7'($urandom_range(127, 0));
				end else if (roll < 91) begin
					op = KIND_INSERT;
					if ($urandom_range(9) < 8)
						pos = 7'($urandom_range(fill_hint, 0));
					else
						pos = 7'($urandom_range(127, 0));
				end else if (roll < 95) begin
					op  = KIND_UNUSED;
					pos = 7'($urandom_range(127, 0));
				end else begin
					// read exactly at the count
					op  = KIND_READ;
					pos = fill_hint[6:0];
				end
				offer_op(op, word, pos);
			end
			drain_replies();
		end

		// Settle: let any stray reply show up before the verdict.
		repeat (16) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("insertable_shift_array_tb: PASS");
		else
			$display("insertable_shift_array_tb: FAIL");
		$finish;
	end

endmodule
